>>> sv/p12bcs_pkg.sv
`default_nettype none
package p12bcs_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_DIM_W  = 13;
  localparam int CFG_PAT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 12;
  localparam int CH_W       = 2;
  localparam int ADDR_W     = 24;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 2'd2;

  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

  localparam logic [CFG_PAT_W-1:0] PAT_RGGB = 2'd0;
  localparam logic [CFG_PAT_W-1:0] PAT_BGGR = 2'd1;
  localparam logic [CFG_PAT_W-1:0] PAT_GRBG = 2'd2;
  localparam logic [CFG_PAT_W-1:0] PAT_GBRG = 2'd3;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [CFG_PAT_W-1:0] bayer_pattern;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_value;
    logic [1:0]        parity;
    logic [ADDR_W-1:0] pixel_address;
    logic              frame_last;
  } pix_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [CH_W-1:0] plane_of(input logic [CFG_PAT_W-1:0] pat,
                                               input logic [1:0] sel);
    logic [CH_W-1:0] ch;
    ch = CH_GREEN;
    case (pat)
      PAT_RGGB: begin
        case (sel)
          2'd0:    ch = CH_RED;
          2'd3:    ch = CH_BLUE;
          default: ch = CH_GREEN;
        endcase
      end
      PAT_BGGR: begin
        case (sel)
          2'd0:    ch = CH_BLUE;
          2'd3:    ch = CH_RED;
          default: ch = CH_GREEN;
        endcase
      end
      PAT_GRBG: begin
        case (sel)
          2'd1:    ch = CH_RED;
          2'd2:    ch = CH_BLUE;
          default: ch = CH_GREEN;
        endcase
      end
      default: begin
        case (sel)
          2'd1:    ch = CH_BLUE;
          2'd2:    ch = CH_RED;
          default: ch = CH_GREEN;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> sv/p12bcs_front.sv
`default_nettype none
module p12bcs_front
  import p12bcs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   in_stall,
  input  wire q_stat_t           q_stat,
  output logic                   push,
  output pix_item_t              push_item
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DW_A  = $clog2(MAX_WIDTH + 1);
  localparam int DW_B  = $clog2(MAX_HEIGHT + 1);
  localparam int DW_C  = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int DW    = ((DW_C > CFG_DIM_W) ? DW_C : CFG_DIM_W) + 1;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   held_byte_r, held_byte_nxt;
  logic [3:0]          held_nib_r, held_nib_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  logic [DW-1:0] fw, fh, w_c, h_c;
  logic          accept, row_end, last;

  always_comb begin
    fw  = DW'(cfg.frame_width);
    fh  = DW'(cfg.frame_height);
    w_c = (fw == '0) ? DW'(1) : ((fw > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : fw);
    h_c = (fh == '0) ? DW'(1) : ((fh > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : fh);
  end

  assign row_end  = DW'(col_r) >= (w_c - DW'(1));
  assign last     = row_end && (DW'(row_r) >= (h_c - DW'(1)));
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign push     = accept && (phase_r != PH_FIRST);

  always_comb begin
    push_item.parity        = {row_r[0], col_r[0]};
    push_item.pixel_address = addr_r;
    push_item.frame_last    = last;
    if (phase_r == PH_SECOND) begin
      push_item.pixel_value = {held_byte_r, in_byte[7:4]};
    end else begin
      push_item.pixel_value = {held_nib_r, in_byte};
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    held_byte_nxt = held_byte_r;
    held_nib_nxt  = held_nib_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    addr_nxt      = addr_r;
    if (accept) begin
      case (phase_r)
        PH_FIRST: begin
          held_byte_nxt = in_byte;
          phase_nxt     = PH_SECOND;
        end
        PH_SECOND: begin
          held_nib_nxt = in_byte[3:0];
          phase_nxt    = last ? PH_FIRST : PH_THIRD;
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
    if (push) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        addr_nxt = '0;
      end else begin
        addr_nxt = addr_r + 1'b1;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      held_byte_r <= '0;
      held_nib_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      addr_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      held_byte_r <= held_byte_nxt;
      held_nib_r  <= held_nib_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      addr_r      <= addr_nxt;
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && last) |=> (col_r == '0 && row_r == '0 && addr_r == '0 && phase_r == PH_FIRST))
    else $error("counters not cleared at frame end");

  a_addr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !last) |=> (addr_r == $past(addr_r) + 1'b1))
    else $error("flat address did not advance");

endmodule
`default_nettype wire

>>> sv/p12bcs_queue.sv
`default_nettype none
module p12bcs_queue
  import p12bcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pix_item_t push_item,
  input  wire logic      pop,
  output pix_item_t      pop_item,
  output q_stat_t        q_stat
);

  pix_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> sv/p12bcs_back.sv
`default_nettype none
module p12bcs_back
  import p12bcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire q_stat_t           q_stat,
  input  wire pix_item_t         pop_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PIX_W-1:0]       out_pixel_value,
  output logic [CH_W-1:0]        out_color_channel,
  output logic [ADDR_W-1:0]      out_pixel_address,
  output logic                   out_frame_last
);

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  pix_r;
  logic [CH_W-1:0]   ch_r;
  logic [ADDR_W-1:0] addr_r;
  logic              last_r;

  assign pop           = q_stat.valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r  <= pop_item.pixel_value;
      ch_r   <= plane_of(cfg.bayer_pattern, pop_item.parity);
      addr_r <= pop_item.pixel_address;
      last_r <= pop_item.frame_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_value   = pix_r;
  assign out_color_channel = ch_r;
  assign out_pixel_address = addr_r;
  assign out_frame_last    = last_r;

  a_load_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && pix_r == $past(pop_item.pixel_value)))
    else $error("output register not loaded on pop");

endmodule
`default_nettype wire

>>> sv/packed12_bayer_channel_splitter_top.sv
// Packed 12-bit raw unpacker and Bayer plane splitter.
// Input channel: one raw byte per word on in_packed_byte, in_valid / in_stall.
// Every three bytes carry two 12-bit pixels, first pixel high-aligned.
// Result channel: one pixel per word with its plane (0 red, 1 green, 2 blue),
// its address row * width + column and a frame-last flag, out_valid / out_stall.
// The first byte of a group gives no word; the second and third give one each.
// Throughput: one byte per cycle while in_stall is low, with unpack and counter
// update in the front stage; pixels leave at up to one per cycle while out_stall is low.
// A pixel's word is written into the queue when the byte that completes it is
// taken, then moves to the output register once that is empty or being taken.
// A two-entry queue parts the front from the output register, so bytes keep
// flowing while a result waits; in_stall rises only when that queue is full.
// Configuration: cfg_we, cfg_index (0 width, 1 height, 2 pattern), cfg_wdata;
// write only while idle. Zero dimensions count as 1, large ones saturate.
// Reset (rst_n low, synchronous) restores 1920 x 1080 RGGB, empties the queue
// and clears the byte phase and the row, column and address counters.
// At frame end all counters return to zero and the phase returns to the first byte.
`default_nettype none
module packed12_bayer_channel_splitter_top
  import p12bcs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_packed_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_pixel_value,
  output logic [CH_W-1:0]            out_color_channel,
  output logic [ADDR_W-1:0]          out_pixel_address,
  output logic                       out_frame_last
);

  cfg_t      cfg_r, cfg_nxt;
  q_stat_t   q_stat;
  pix_item_t push_item, pop_item;
  logic      push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:   cfg_nxt.frame_width   = cfg_wdata[CFG_DIM_W-1:0];
        CFG_IDX_HEIGHT:  cfg_nxt.frame_height  = cfg_wdata[CFG_DIM_W-1:0];
        CFG_IDX_PATTERN: cfg_nxt.bayer_pattern = cfg_wdata[CFG_PAT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= RST_FRAME_WIDTH;
      cfg_r.frame_height  <= RST_FRAME_HEIGHT;
      cfg_r.bayer_pattern <= PAT_RGGB;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  p12bcs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_byte   (in_packed_byte),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  p12bcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  p12bcs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .pop_item          (pop_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_color_channel (out_color_channel),
    .out_pixel_address (out_pixel_address),
    .out_frame_last    (out_frame_last)
  );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import p12bcs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_BYTES = 146;
  localparam int HOLD_CYCLES = 150;

  typedef enum logic [2:0] {
    GRP_FIRST  = 3'b001,
    GRP_SECOND = 3'b010,
    GRP_THIRD  = 3'b100
  } grp_pos_t;
  typedef enum logic [1:0] {ROW_BYTE, ROW_WIDTH, ROW_HEIGHT, ROW_PATTERN} row_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [CH_W-1:0]   chan;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } pixel_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    pixel_t                px;
  } stim_row_t;

  localparam pixel_t NO_PX = '0;

  localparam logic [CH_W-1:0] PLANE_MAP [4][4] = '{
    '{CH_RED,   CH_GREEN, CH_GREEN, CH_BLUE},
    '{CH_BLUE,  CH_GREEN, CH_GREEN, CH_RED},
    '{CH_GREEN, CH_RED,   CH_BLUE,  CH_GREEN},
    '{CH_GREEN, CH_BLUE,  CH_RED,   CH_GREEN}
  };

  localparam stim_row_t DIR_ROWS [30] = '{
    '{ROW_BYTE,    13'h0FF, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h0FF, 1'b1, '{12'hFFF, CH_RED,   24'd0, 1'b0}},
    '{ROW_BYTE,    13'h0FF, 1'b1, '{12'hFFF, CH_GREEN, 24'd1, 1'b0}},
    '{ROW_BYTE,    13'h000, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h000, 1'b1, '{12'h000, CH_RED,   24'd2, 1'b0}},
    '{ROW_BYTE,    13'h000, 1'b1, '{12'h000, CH_GREEN, 24'd3, 1'b0}},
    '{ROW_BYTE,    13'h0AB, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h0CD, 1'b1, '{12'hABC, CH_RED,   24'd4, 1'b0}},
    '{ROW_BYTE,    13'h0EF, 1'b1, '{12'hDEF, CH_GREEN, 24'd5, 1'b0}},
    '{ROW_WIDTH,   13'd3,   1'b0, NO_PX},
    '{ROW_HEIGHT,  13'd2,   1'b0, NO_PX},
    '{ROW_PATTERN, CFG_DATA_W'(PAT_BGGR), 1'b0, NO_PX},
    '{ROW_BYTE,    13'h012, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h034, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h056, 1'b0, NO_PX},
    '{ROW_WIDTH,   13'd0,   1'b0, NO_PX},
    '{ROW_HEIGHT,  13'd0,   1'b0, NO_PX},
    '{ROW_PATTERN, CFG_DATA_W'(PAT_GRBG), 1'b0, NO_PX},
    '{ROW_BYTE,    13'h05A, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h03C, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h077, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h088, 1'b1, '{12'h778, CH_GREEN, 24'd0, 1'b1}},
    '{ROW_BYTE,    13'h099, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h0AA, 1'b1, '{12'h99A, CH_GREEN, 24'd0, 1'b1}},
    '{ROW_WIDTH,   13'd8191, 1'b0, NO_PX},
    '{ROW_HEIGHT,  13'd8191, 1'b0, NO_PX},
    '{ROW_PATTERN, CFG_DATA_W'(PAT_GBRG), 1'b0, NO_PX},
    '{ROW_BYTE,    13'h001, 1'b0, NO_PX},
    '{ROW_BYTE,    13'h002, 1'b1, '{12'h010, CH_GREEN, 24'd0, 1'b0}},
    '{ROW_BYTE,    13'h003, 1'b1, '{12'h203, CH_BLUE,  24'd1, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_packed_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_pixel_value;
  logic [CH_W-1:0]       out_color_channel;
  logic [ADDR_W-1:0]     out_pixel_address;
  logic                  out_frame_last;

  packed12_bayer_channel_splitter_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_packed_byte    (in_packed_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_color_channel (out_color_channel),
    .out_pixel_address (out_pixel_address),
    .out_frame_last    (out_frame_last)
  );

  // unpacker state and register copies
  grp_pos_t              grp_pos;
  logic [BYTE_W-1:0]     held_byte;
  logic [3:0]            held_nib;
  int                    col_cnt;
  int                    row_cnt;
  logic [ADDR_W-1:0]     flat_addr;
  logic [CFG_DIM_W-1:0]  cur_width;
  logic [CFG_DIM_W-1:0]  cur_height;
  logic [CFG_PAT_W-1:0]  cur_pattern;

  pixel_t pending_pixels [$];
  int     failures;
  int     bytes_sent;
  int     pixels_checked;
  int     frames_seen;
  int     reg_writes;
  int     cycles;
  bit     quiet_run;
  int     hold_reqs;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic pixel_t place_pixel(input logic [PIX_W-1:0] v);
    int     w;
    int     h;
    bit     row_end;
    bit     last;
    pixel_t px;
    w = clamp_dim(cur_width, DEF_MAX_WIDTH);
    h = clamp_dim(cur_height, DEF_MAX_HEIGHT);
    row_end = col_cnt >= w - 1;
    last = row_end && (row_cnt >= h - 1);
    px.value = v;
    px.chan = PLANE_MAP[cur_pattern][{row_cnt[0], col_cnt[0]}];
    px.addr = flat_addr;
    px.last = last;
    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
      flat_addr = '0;
      grp_pos = GRP_FIRST;
    end else begin
      flat_addr = flat_addr + 1'b1;
      if (row_end) begin
        col_cnt = 0;
        row_cnt = row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
    end
    return px;
  endfunction

  function automatic bit unpack_step(input logic [BYTE_W-1:0] b, output pixel_t px);
    px = NO_PX;
    if (grp_pos == GRP_FIRST) begin
      held_byte = b;
      grp_pos = GRP_SECOND;
      return 1'b0;
    end
    if (grp_pos == GRP_SECOND) begin
      held_nib = b[3:0];
      grp_pos = GRP_THIRD;
      px = place_pixel({held_byte, b[7:4]});
    end else begin
      grp_pos = GRP_FIRST;
      px = place_pixel({held_nib, b});
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit use_typed,
                           input pixel_t typed_px);
    pixel_t px;
    while (!quiet_run && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packed_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (unpack_step(b, px)) pending_pixels.push_back(use_typed ? typed_px : px);
  endtask

  // drop valid, wait out every pending pixel and the tail of a held byte
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_IDX_WIDTH:   cur_width = data;
      CFG_IDX_HEIGHT:  cur_height = data;
      CFG_IDX_PATTERN: cur_pattern = data[CFG_PAT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 13'd4096;
      2:       return 13'd8191;
      default: return CFG_DATA_W'($urandom_range(9, 1));
    endcase
  endfunction

  // receiver: random stall, plus a long hold on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_run && ($urandom_range(99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: value %h addr %0d", out_pixel_value,
               out_pixel_address);
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_frame_last === 1'b1) frames_seen++;
        if (out_pixel_value !== want.value) begin
          $error("pixel_value: expected %h, got %h", want.value, out_pixel_value);
          failures++;
        end
        if (out_color_channel !== want.chan) begin
          $error("color_channel: expected %0d, got %0d", want.chan, out_color_channel);
          failures++;
        end
        if (out_pixel_address !== want.addr) begin
          $error("pixel_address: expected %0d, got %0d", want.addr, out_pixel_address);
          failures++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
               pending_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    grp_pos = GRP_FIRST;
    held_byte = '0;
    held_nib = '0;
    col_cnt = 0;
    row_cnt = 0;
    flat_addr = '0;
    cur_width = RST_FRAME_WIDTH;
    cur_height = RST_FRAME_HEIGHT;
    cur_pattern = PAT_RGGB;
    failures = 0;
    bytes_sent = 0;
    pixels_checked = 0;
    frames_seen = 0;
    reg_writes = 0;
    cycles = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_packed_byte <= '0;
    quiet_run <= 1'b0;
    hold_reqs <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_BYTE: send_byte(DIR_ROWS[i].data[BYTE_W-1:0], DIR_ROWS[i].typed,
                            DIR_ROWS[i].px);
        ROW_WIDTH: begin
          settle();
          cfg_write(CFG_IDX_WIDTH, DIR_ROWS[i].data);
        end
        ROW_HEIGHT: begin
          settle();
          cfg_write(CFG_IDX_HEIGHT, DIR_ROWS[i].data);
        end
        default: begin
          settle();
          cfg_write(CFG_IDX_PATTERN, DIR_ROWS[i].data);
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      cfg_write(CFG_IDX_WIDTH, pick_dim());
      cfg_write(CFG_IDX_HEIGHT, pick_dim());
      cfg_write(CFG_IDX_PATTERN, CFG_DATA_W'($urandom_range(3)));
      quiet_run <= (p == 1);
      if (p == 4) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < PHASE_BYTES; k++)
        send_byte(BYTE_W'($urandom_range(255)), 1'b0, NO_PX);
    end

    settle();
    repeat (4) @(posedge clk);
    $display("run: %0d bytes in, %0d pixels checked, %0d frame ends, %0d register writes",
             bytes_sent, pixels_checked, frames_seen, reg_writes);
    $display("run: all four patterns, zero and saturated geometry, long output hold");
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> packed12_bayer_channel_splitter_top.f
sv/p12bcs_pkg.sv
sv/p12bcs_front.sv
sv/p12bcs_queue.sv
sv/p12bcs_back.sv
sv/packed12_bayer_channel_splitter_top.sv
test/tb_top.sv
